// File: hdl/s2sdm_pkg.sv
`default_nettype none

package s2sdm_pkg;

   // Default widths of the sample path and of the gain fraction
   localparam int SAMPLE_WIDTH_DEF   = 24;
   localparam int GAIN_FRAC_BITS_DEF = 16;

   // Speaker slots: front left, front right, centre, LFE (dropped), back left, back right
   localparam int NUM_SLOTS      = 6;
   localparam int SLOT_IDX_WIDTH = 3;
   localparam int SLOT_FL        = 0;
   localparam int SLOT_FR        = 1;
   localparam int SLOT_FC        = 2;
   localparam int SLOT_BL        = 4;
   localparam int SLOT_BR        = 5;

   // Register file
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int MASK_WIDTH      = 6;
   localparam int COUNT_WIDTH     = 4;
   localparam int BITS_WIDTH      = 5;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPK_MASK    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHAN_NUM    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_BITS = 2'd2;

   localparam logic [MASK_WIDTH-1:0]  MASK_RESET  = 6'h00;
   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 4'd6;
   localparam logic [BITS_WIDTH-1:0]  BITS_RESET  = 5'd16;

   // Narrowest saturation width
   localparam int MIN_BITS = 8;

   // Gain ratios: rear 0.6 * 0.7 = 0.42, centre 0.7
   localparam longint unsigned BACK_GAIN_NUM = 42;
   localparam longint unsigned BACK_GAIN_DEN = 100;
   localparam longint unsigned FC_GAIN_NUM   = 7;
   localparam longint unsigned FC_GAIN_DEN   = 10;

   // Layouts chosen from the channel count when no mask is set
   localparam logic [MASK_WIDTH-1:0] MASK_NONE   = 6'h00;
   localparam logic [MASK_WIDTH-1:0] MASK_MONO   = 6'h04;
   localparam logic [MASK_WIDTH-1:0] MASK_STEREO = 6'h03;
   localparam logic [MASK_WIDTH-1:0] MASK_3CH    = 6'h07;
   localparam logic [MASK_WIDTH-1:0] MASK_QUAD   = 6'h33;
   localparam logic [MASK_WIDTH-1:0] MASK_5CH    = 6'h37;
   localparam logic [MASK_WIDTH-1:0] MASK_FULL   = 6'h3F;

   function automatic logic [MASK_WIDTH-1:0] derive_mask(input logic [COUNT_WIDTH-1:0] count);
      logic [MASK_WIDTH-1:0] m;
      case (count)
         4'd0: m = MASK_NONE;
         4'd1: m = MASK_MONO;
         4'd2: m = MASK_STEREO;
         4'd3: m = MASK_3CH;
         4'd4: m = MASK_QUAD;
         4'd5: m = MASK_5CH;
         default: m = MASK_FULL;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// File: hdl/s2sdm_front.sv
`default_nettype none

module s2sdm_front #(
   parameter int SAMPLE_WIDTH   = s2sdm_pkg::SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = s2sdm_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic [s2sdm_pkg::NUM_SLOTS-1:0][SAMPLE_WIDTH-1:0] samples,
   input  wire logic [s2sdm_pkg::MASK_WIDTH-1:0]                  spk_mask,
   input  wire logic [s2sdm_pkg::COUNT_WIDTH-1:0]                 chan_num,
   output logic signed [SAMPLE_WIDTH-1:0]                         front_left,
   output logic signed [SAMPLE_WIDTH-1:0]                         front_right,
   output logic signed [SAMPLE_WIDTH+GAIN_FRAC_BITS+1:0]          rear_prod,
   output logic signed [SAMPLE_WIDTH+GAIN_FRAC_BITS:0]            center_prod
);
   import s2sdm_pkg::*;

   // Gains rounded to nearest at GAIN_FRAC_BITS fraction bits
   localparam longint unsigned BACK_GAIN_W =
      ((BACK_GAIN_NUM << GAIN_FRAC_BITS) + BACK_GAIN_DEN / 2) / BACK_GAIN_DEN;
   localparam longint unsigned FC_GAIN_W =
      ((FC_GAIN_NUM << GAIN_FRAC_BITS) + FC_GAIN_DEN / 2) / FC_GAIN_DEN;
   localparam logic [GAIN_FRAC_BITS-1:0] BACK_GAIN_Q = BACK_GAIN_W[GAIN_FRAC_BITS-1:0];
   localparam logic [GAIN_FRAC_BITS-1:0] FC_GAIN_Q   = FC_GAIN_W[GAIN_FRAC_BITS-1:0];

   logic [MASK_WIDTH-1:0]                        eff_mask;
   logic [NUM_SLOTS-1:0][SAMPLE_WIDTH-1:0]       slot;
   logic signed [SAMPLE_WIDTH:0]                 rear_sum;

   // Fall back to the layout implied by the channel count
   assign eff_mask = (spk_mask != MASK_NONE) ? spk_mask : derive_mask(chan_num);

   // Route the k-th set mask bit to the k-th input word; absent slots read zero
   always_comb begin
      logic [SLOT_IDX_WIDTH-1:0] pos;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         pos = '0;
         for (int j = 0; j < NUM_SLOTS; j++) begin
            if (j < s && eff_mask[j]) begin
               pos = pos + SLOT_IDX_WIDTH'(1);
            end
         end
         slot[s] = eff_mask[s] ? samples[pos] : '0;
      end
   end

   assign front_left  = signed'(slot[SLOT_FL]);
   assign front_right = signed'(slot[SLOT_FR]);

   // Constant-gain products of the rear pair and the centre
   assign rear_sum    = (SAMPLE_WIDTH+1)'(signed'(slot[SLOT_BL]))
                      + (SAMPLE_WIDTH+1)'(signed'(slot[SLOT_BR]));
   assign rear_prod   = rear_sum * signed'({1'b0, BACK_GAIN_Q});
   assign center_prod = signed'(slot[SLOT_FC]) * signed'({1'b0, FC_GAIN_Q});

endmodule

`default_nettype wire

// File: hdl/s2sdm_mix.sv
`default_nettype none

module s2sdm_mix #(
   parameter int SAMPLE_WIDTH   = s2sdm_pkg::SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = s2sdm_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic signed [SAMPLE_WIDTH-1:0]                front_smp,
   input  wire logic signed [SAMPLE_WIDTH+GAIN_FRAC_BITS+1:0] rear_prod,
   input  wire logic signed [SAMPLE_WIDTH+GAIN_FRAC_BITS:0]   center_prod,
   input  wire logic                                          rear_sub,
   input  wire logic [s2sdm_pkg::BITS_WIDTH-1:0]              sample_bits,
   output logic signed [SAMPLE_WIDTH-1:0]                     mix_out
);
   import s2sdm_pkg::*;

   localparam int AW = SAMPLE_WIDTH + GAIN_FRAC_BITS + 3;
   localparam int RW = AW - GAIN_FRAC_BITS;
   localparam int BW = $clog2(SAMPLE_WIDTH + 1);
   localparam logic [AW-1:0] HALF =
      {{(AW-GAIN_FRAC_BITS){1'b0}}, 1'b1, {(GAIN_FRAC_BITS-1){1'b0}}};

   logic signed [AW-1:0] front_ext;
   logic signed [AW-1:0] rear_ext;
   logic signed [AW-1:0] rear_term;
   logic signed [AW-1:0] center_ext;
   logic signed [AW-1:0] sum;
   logic [AW-1:0]        biased;
   logic signed [RW-1:0] rnd;
   logic [BW-1:0]        bits_eff;
   logic signed [RW-1:0] hi;
   logic signed [RW-1:0] lo;
   logic signed [RW-1:0] sat;

   // Exact sum with the front sample scaled up to the gain fraction
   assign front_ext  = AW'(front_smp) <<< GAIN_FRAC_BITS;
   assign rear_ext   = AW'(rear_prod);
   assign rear_term  = rear_sub ? -rear_ext : rear_ext;
   assign center_ext = AW'(center_prod);
   assign sum        = front_ext + rear_term + center_ext;

   // Round half away from zero: add half, less one when negative, then drop the fraction
   assign biased = sum + HALF - AW'(sum[AW-1]);
   assign rnd    = signed'(biased[AW-1:GAIN_FRAC_BITS]);

   // Clamp the configured width to the supported range
   always_comb begin
      if (int'(sample_bits) < MIN_BITS) begin
         bits_eff = BW'(MIN_BITS);
      end else if (int'(sample_bits) > SAMPLE_WIDTH) begin
         bits_eff = BW'(SAMPLE_WIDTH);
      end else begin
         bits_eff = BW'(sample_bits);
      end
   end

   assign hi = (RW'(1) << (bits_eff - BW'(1))) - RW'(1);
   assign lo = ~hi;

   // Saturate to the signed sample range
   always_comb begin
      if (rnd > hi) begin
         sat = hi;
      end else if (rnd < lo) begin
         sat = lo;
      end else begin
         sat = rnd;
      end
   end

   assign mix_out = signed'(sat[SAMPLE_WIDTH-1:0]);

endmodule

`default_nettype wire

// File: hdl/surround_to_stereo_downmix.sv
// Channel  Direction  Handshake          Word
// req      in         req_valid/stall    six input samples of one frame
// rsp      out        rsp_valid/stall    downmixed left and right samples
// csr      in         csr_valid/ready    register index and write data
//
// One frame per cycle sustained while rsp_stall is low; an accepted word passes the input
// register, the product register and then the result register, which drives rsp_valid.
// Synchronous active-high reset clears the valid bits and the configuration registers.
// A stalled result holds in place while earlier stages keep filling; req_stall
// rises only when every stage holds a frame and the result is stalled.
`default_nettype none

module surround_to_stereo_downmix #(
   parameter int SAMPLE_WIDTH   = s2sdm_pkg::SAMPLE_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = s2sdm_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0]          req_sample_in_0,
   input  wire logic signed [SAMPLE_WIDTH-1:0]          req_sample_in_1,
   input  wire logic signed [SAMPLE_WIDTH-1:0]          req_sample_in_2,
   input  wire logic signed [SAMPLE_WIDTH-1:0]          req_sample_in_3,
   input  wire logic signed [SAMPLE_WIDTH-1:0]          req_sample_in_4,
   input  wire logic signed [SAMPLE_WIDTH-1:0]          req_sample_in_5,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]               rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0]               rsp_right_out,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [s2sdm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [s2sdm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import s2sdm_pkg::*;

   localparam int RPW = SAMPLE_WIDTH + GAIN_FRAC_BITS + 2;
   localparam int CPW = SAMPLE_WIDTH + GAIN_FRAC_BITS + 1;

   // Configuration registers
   logic [MASK_WIDTH-1:0]  mask_ff,  mask_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [BITS_WIDTH-1:0]  bits_ff,  bits_in;

   // Pipeline valid bits
   logic in_vld_ff,   in_vld_in;
   logic prod_vld_ff, prod_vld_in;
   logic rsp_vld_ff,  rsp_vld_in;
   logic in_ready, prod_ready, out_ready;

   // Pipeline payload
   logic [NUM_SLOTS-1:0][SAMPLE_WIDTH-1:0] smp_ff, smp_in;
   logic signed [SAMPLE_WIDTH-1:0] fl_ff, fl_in;
   logic signed [SAMPLE_WIDTH-1:0] fr_ff, fr_in;
   logic signed [RPW-1:0]          rear_ff, rear_in;
   logic signed [CPW-1:0]          cen_ff, cen_in;
   logic signed [SAMPLE_WIDTH-1:0] left_ff, left_in;
   logic signed [SAMPLE_WIDTH-1:0] right_ff, right_in;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      mask_in  = mask_ff;
      count_in = count_ff;
      bits_in  = bits_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SPK_MASK:    mask_in  = csr_wdata[MASK_WIDTH-1:0];
            CSR_CHAN_NUM:    count_in = csr_wdata[COUNT_WIDTH-1:0];
            CSR_SAMPLE_BITS: bits_in  = csr_wdata[BITS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Advance each stage when the next one is empty or moving
   assign out_ready  = !rsp_vld_ff || !rsp_stall;
   assign prod_ready = !prod_vld_ff || out_ready;
   assign in_ready   = !in_vld_ff || prod_ready;
   assign req_stall  = !in_ready;

   assign in_vld_in   = in_ready   ? req_valid   : in_vld_ff;
   assign prod_vld_in = prod_ready ? in_vld_ff   : prod_vld_ff;
   assign rsp_vld_in  = out_ready  ? prod_vld_ff : rsp_vld_ff;

   // Input register
   assign smp_in = in_ready
      ? {req_sample_in_5, req_sample_in_4, req_sample_in_3,
         req_sample_in_2, req_sample_in_1, req_sample_in_0}
      : smp_ff;

   // Route and weight
   logic signed [SAMPLE_WIDTH-1:0] front_left, front_right;
   logic signed [RPW-1:0]          rear_prod;
   logic signed [CPW-1:0]          center_prod;

   s2sdm_front #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_front (
      .samples     (smp_ff),
      .spk_mask    (mask_ff),
      .chan_num    (count_ff),
      .front_left  (front_left),
      .front_right (front_right),
      .rear_prod   (rear_prod),
      .center_prod (center_prod)
   );

   assign fl_in   = prod_ready ? front_left  : fl_ff;
   assign fr_in   = prod_ready ? front_right : fr_ff;
   assign rear_in = prod_ready ? rear_prod   : rear_ff;
   assign cen_in  = prod_ready ? center_prod : cen_ff;

   // Sum, round and saturate each side; right takes the rear pair negated
   logic signed [SAMPLE_WIDTH-1:0] mix_left, mix_right;

   s2sdm_mix #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_mix_left (
      .front_smp   (fl_ff),
      .rear_prod   (rear_ff),
      .center_prod (cen_ff),
      .rear_sub    (1'b0),
      .sample_bits (bits_ff),
      .mix_out     (mix_left)
   );

   s2sdm_mix #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_mix_right (
      .front_smp   (fr_ff),
      .rear_prod   (rear_ff),
      .center_prod (cen_ff),
      .rear_sub    (1'b1),
      .sample_bits (bits_ff),
      .mix_out     (mix_right)
   );

   // Result register: hold while stalled
   assign left_in  = out_ready ? mix_left  : left_ff;
   assign right_in = out_ready ? mix_right : right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= MASK_RESET;
         count_ff    <= COUNT_RESET;
         bits_ff     <= BITS_RESET;
         in_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         mask_ff     <= mask_in;
         count_ff    <= count_in;
         bits_ff     <= bits_in;
         in_vld_ff   <= in_vld_in;
         prod_vld_ff <= prod_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff   <= smp_in;
      fl_ff    <= fl_in;
      fr_ff    <= fr_in;
      rear_ff  <= rear_in;
      cen_ff   <= cen_in;
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;

endmodule

`default_nettype wire
